>>> rtl/tpag_pkg.sv
// tpag_pkg: shared constants, codes and types of the tensor permute address generator
// no dependencies; imported by tpag_axis_cell and tensor_permute_address_generator
`default_nettype none

package tpag_pkg;

   localparam int MAX_RANK  = 8;
   localparam int DIM_BITS  = 16;
   localparam int ADDR_BITS = 48;

   localparam int AXIS_BITS    = $clog2(MAX_RANK);
   localparam int RANK_BITS    = 4;
   localparam int SLOT_BITS    = 16;
   localparam int SHAPE_BITS   = 64;
   localparam int PERM_BITS    = 24;
   localparam int PERM_FIELD   = 3;
   localparam int EB_BITS      = 5;
   localparam int EB_MAX       = 16;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [ADDR_BITS:0] ADDR_CAP = {1'b1, {ADDR_BITS{1'b0}}};

   typedef enum logic [2:0] {
      STAT_ELEM       = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_BAD_PERM   = 3'd2,
      STAT_TOO_LARGE  = 3'd3,
      STAT_NOT_ACTIVE = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RANK        = 3'd0,
      CSR_SHAPE_LOW   = 3'd1,
      CSR_SHAPE_HIGH  = 3'd2,
      CSR_PERM        = 3'd3,
      CSR_REVERSE     = 3'd4,
      CSR_ELEM_BYTES  = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_PROD,
      FSM_CHECK,
      FSM_LD_A,
      FSM_LD_B,
      FSM_LD_C
   } fsm_type;

   typedef struct packed {
      logic                 en;
      logic [DIM_BITS-1:0]  osh;
      logic [ADDR_BITS-1:0] inc;
   } cell_load_type;

endpackage

`default_nettype wire

>>> rtl/tpag_axis_cell.sv
// tpag_axis_cell: one odometer digit of the output walk, with its source address increment
// depends on tpag_pkg
`default_nettype none

module tpag_axis_cell import tpag_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           clr,
   input  wire cell_load_type  load,
   input  wire logic           step,
   input  wire logic           carry_in,
   output logic                carry_out,
   output logic [ADDR_BITS-1:0] inc_out,
   output logic                at_end
);

   logic                 used_ff, used_in;
   logic [DIM_BITS-1:0]  coord_ff, coord_in;
   logic [DIM_BITS-1:0]  osh_ff, osh_in;
   logic [ADDR_BITS-1:0] inc_ff, inc_in;
   logic                 wrap;
   logic                 bump;
   logic [DIM_BITS:0]    coord_p1;
   logic [DIM_BITS:0]    next_p1;

   always_comb begin
      coord_p1  = {1'b0, coord_ff} + 1'b1;
      wrap      = coord_p1 == {1'b0, osh_ff};
      bump      = step & carry_in & used_ff;
      carry_out = used_ff ? (carry_in & wrap) : carry_in;
      inc_out   = (bump & ~wrap) ? inc_ff : '0;
      used_in   = used_ff;
      coord_in  = coord_ff;
      osh_in    = osh_ff;
      inc_in    = inc_ff;
      if (clr) begin
         used_in  = 1'b0;
         coord_in = '0;
      end else if (load.en) begin
         used_in  = 1'b1;
         coord_in = '0;
         osh_in   = load.osh;
         inc_in   = load.inc;
      end else if (bump) begin
         coord_in = wrap ? '0 : coord_p1[DIM_BITS-1:0];
      end
      next_p1 = {1'b0, coord_in} + 1'b1;
      at_end  = ~used_ff | (next_p1 == {1'b0, osh_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         coord_ff <= '0;
      end else begin
         used_ff  <= used_in;
         coord_ff <= coord_in;
      end
      osh_ff <= osh_in;
      inc_ff <= inc_in;
   end

endmodule

`default_nettype wire

>>> rtl/tensor_permute_address_generator.sv
// tensor_permute_address_generator: top level, configuration registers, start sequencer
// and the row of tpag_axis_cell odometer digits; depends on tpag_pkg
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | start_req, src_base, dst_base
//  rsp     | out       | rsp_valid / rsp_stall | src_addr, dst_addr, last, status
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// continue transactions: one per cycle while rsp_stall is low, carry ripples through the
// axis cells and one 48-bit add updates the source address
// start transaction: stride product loop, a check, then a three-step multiply/accumulate
// per axis to load the cells; rank, permutation and idle continue status results are
// set in the idle state, zero-dimension empty and too-large results after the product loop
// reset clears all control state; the result register holds while rsp_stall is high
`default_nettype none

module tensor_permute_address_generator import tpag_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_start_req,
   input  wire logic [ADDR_BITS-1:0]     req_src_base,
   input  wire logic [ADDR_BITS-1:0]     req_dst_base,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [ADDR_BITS-1:0]          rsp_src_addr,
   output logic [ADDR_BITS-1:0]          rsp_dst_addr,
   output logic                          rsp_last,
   output logic [2:0]                    rsp_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // configuration
   logic [RANK_BITS-1:0]  rank_ff;
   logic [SHAPE_BITS-1:0] shape_low_ff, shape_high_ff;
   logic [PERM_BITS-1:0]  perm_ff;
   logic                  rev_ff;
   logic [EB_BITS-1:0]    eb_ff;

   // control
   fsm_type               state_ff, state_in;
   logic                  active_ff, active_in;
   logic                  rv_ff, rv_in;
   logic [AXIS_BITS-1:0]  k_ff, k_in;
   logic                  zero_ff, zero_in;

   // payload
   logic [ADDR_BITS-1:0]  src_ff, src_in;
   logic [ADDR_BITS-1:0]  dst_ff, dst_in;
   logic                  last_ff, last_in;
   status_type            stat_ff, stat_in;
   logic [ADDR_BITS-1:0]  sbase_ff, sbase_in;
   logic [ADDR_BITS-1:0]  dbase_ff, dbase_in;
   logic [RANK_BITS-1:0]  r_ff, r_in;
   logic [AXIS_BITS-1:0]  pv_ff [MAX_RANK];
   logic [AXIS_BITS-1:0]  pv_in [MAX_RANK];
   logic [DIM_BITS-1:0]   ish_ff [MAX_RANK];
   logic [DIM_BITS-1:0]   ish_in [MAX_RANK];
   logic [ADDR_BITS-1:0]  st_ff [MAX_RANK];
   logic                  st_we;
   logic [EB_BITS-1:0]    ebh_ff, ebh_in;
   logic [ADDR_BITS:0]    prod_ff, prod_in;
   logic [ADDR_BITS-1:0]  stride_ff, stride_in;
   logic [DIM_BITS-1:0]   osh_ff, osh_in;
   logic [ADDR_BITS-1:0]  w_ff, w_in;
   logic [ADDR_BITS-1:0]  back_ff, back_in;

   logic                  req_take;
   logic                  rsp_take;
   logic [2*SHAPE_BITS-1:0] shape_all;
   logic [RANK_BITS-1:0]  pfull;
   logic [MAX_RANK-1:0]   seen;
   logic                  bad;
   logic [AXIS_BITS-1:0]  pv_new [MAX_RANK];
   logic [ADDR_BITS+DIM_BITS:0]   prod_mul;
   logic [ADDR_BITS+DIM_BITS-1:0] w_mul;
   logic                  step;
   logic                  clr;
   cell_load_type         cld [MAX_RANK];
   logic [MAX_RANK:0]     carry;
   logic [ADDR_BITS-1:0]  cinc [MAX_RANK];
   logic [MAX_RANK-1:0]   cend;
   logic [ADDR_BITS-1:0]  src_step;

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rv_ff;
   assign rsp_src_addr = src_ff;
   assign rsp_dst_addr = dst_ff;
   assign rsp_last     = last_ff;
   assign rsp_status   = stat_ff;
   assign req_stall    = (state_ff != FSM_IDLE) || (rv_ff && rsp_stall);
   assign req_take     = req_valid && !req_stall;
   assign rsp_take     = rv_ff && !rsp_stall;
   assign shape_all    = {shape_high_ff, shape_low_ff};
   assign prod_mul     = prod_ff * ish_ff[k_ff];
   assign w_mul        = (osh_ff - 1'b1) * stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff       <= '0;
         shape_low_ff  <= '0;
         shape_high_ff <= '0;
         perm_ff       <= '0;
         rev_ff        <= 1'b1;
         eb_ff         <= EB_BITS'(4);
      end else if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_RANK:       rank_ff       <= csr_wdata[RANK_BITS-1:0];
            CSR_SHAPE_LOW:  shape_low_ff  <= csr_wdata;
            CSR_SHAPE_HIGH: shape_high_ff <= csr_wdata;
            CSR_PERM:       perm_ff       <= csr_wdata[PERM_BITS-1:0];
            CSR_REVERSE:    rev_ff        <= csr_wdata[0];
            CSR_ELEM_BYTES: eb_ff         <= csr_wdata[EB_BITS-1:0];
            default: ;
         endcase
      end
   end

   // permutation check on the live configuration
   always_comb begin
      seen = '0;
      bad  = 1'b0;
      for (int i = 0; i < MAX_RANK; i++) begin
         pfull = rev_ff ? (rank_ff - 1'b1 - RANK_BITS'(i))
                        : {1'b0, perm_ff[PERM_FIELD*i +: AXIS_BITS]};
         pv_new[i] = pfull[AXIS_BITS-1:0];
         if (RANK_BITS'(i) < rank_ff) begin
            if (pfull >= rank_ff || seen[pfull[AXIS_BITS-1:0]]) begin
               bad = 1'b1;
            end else begin
               seen[pfull[AXIS_BITS-1:0]] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      rv_in     = rsp_take ? 1'b0 : rv_ff;
      k_in      = k_ff;
      zero_in   = zero_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      last_in   = last_ff;
      stat_in   = stat_ff;
      sbase_in  = sbase_ff;
      dbase_in  = dbase_ff;
      r_in      = r_ff;
      pv_in     = pv_ff;
      ish_in    = ish_ff;
      ebh_in    = ebh_ff;
      prod_in   = prod_ff;
      stride_in = stride_ff;
      osh_in    = osh_ff;
      w_in      = w_ff;
      back_in   = back_ff;
      st_we     = 1'b0;
      step      = 1'b0;
      clr       = 1'b0;
      for (int i = 0; i < MAX_RANK; i++) begin
         cld[i].en  = (state_ff == FSM_LD_B) && (k_ff == AXIS_BITS'(i));
         cld[i].osh = osh_ff;
         cld[i].inc = stride_ff - back_ff;
      end
      case (state_ff)
         FSM_IDLE: begin
            if (req_take) begin
               if (req_start_req) begin
                  active_in = 1'b0;
                  clr       = 1'b1;
                  sbase_in  = req_src_base;
                  dbase_in  = req_dst_base;
                  r_in      = rank_ff;
                  pv_in     = pv_new;
                  for (int i = 0; i < MAX_RANK; i++) begin
                     ish_in[i] = shape_all[SLOT_BITS*i +: DIM_BITS];
                  end
                  if (eb_ff == '0) begin
                     ebh_in = EB_BITS'(1);
                  end else if (eb_ff > EB_BITS'(EB_MAX)) begin
                     ebh_in = EB_BITS'(EB_MAX);
                  end else begin
                     ebh_in = eb_ff;
                  end
                  prod_in = (ADDR_BITS+1)'(ebh_in);
                  zero_in = 1'b0;
                  k_in    = AXIS_BITS'(rank_ff - 1'b1);
                  if (rank_ff == '0) begin
                     rv_in = 1'b1; src_in = '0; dst_in = '0; last_in = 1'b1;
                     stat_in = STAT_EMPTY;
                  end else if (rank_ff > RANK_BITS'(MAX_RANK) || bad) begin
                     rv_in = 1'b1; src_in = '0; dst_in = '0; last_in = 1'b1;
                     stat_in = STAT_BAD_PERM;
                  end else begin
                     state_in = FSM_PROD;
                  end
               end else if (!active_ff) begin
                  rv_in = 1'b1; src_in = '0; dst_in = '0; last_in = 1'b1;
                  stat_in = STAT_NOT_ACTIVE;
               end else begin
                  step      = 1'b1;
                  rv_in     = 1'b1;
                  src_in    = src_ff + src_step;
                  dst_in    = dst_ff + ADDR_BITS'(ebh_ff);
                  last_in   = &cend;
                  stat_in   = STAT_ELEM;
                  active_in = ~(&cend);
               end
            end
         end
         FSM_PROD: begin
            st_we = 1'b1;
            if (ish_ff[k_ff] == '0) begin
               zero_in = 1'b1;
            end
            if (prod_mul >= (ADDR_BITS+DIM_BITS+1)'(ADDR_CAP)) begin
               prod_in = ADDR_CAP;
            end else begin
               prod_in = prod_mul[ADDR_BITS:0];
            end
            if (k_ff == '0) begin
               state_in = FSM_CHECK;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         FSM_CHECK: begin
            k_in    = AXIS_BITS'(r_ff - 1'b1);
            back_in = '0;
            if (zero_ff) begin
               rv_in = 1'b1; src_in = '0; dst_in = '0; last_in = 1'b1;
               stat_in = STAT_EMPTY; state_in = FSM_IDLE;
            end else if (prod_ff >= ADDR_CAP) begin
               rv_in = 1'b1; src_in = '0; dst_in = '0; last_in = 1'b1;
               stat_in = STAT_TOO_LARGE; state_in = FSM_IDLE;
            end else begin
               state_in = FSM_LD_A;
            end
         end
         FSM_LD_A: begin
            stride_in = st_ff[pv_ff[k_ff]];
            osh_in    = ish_ff[pv_ff[k_ff]];
            state_in  = FSM_LD_B;
         end
         FSM_LD_B: begin
            w_in     = w_mul[ADDR_BITS-1:0];
            state_in = FSM_LD_C;
         end
         FSM_LD_C: begin
            back_in = back_ff + w_ff;
            if (k_ff == '0) begin
               rv_in     = 1'b1;
               src_in    = sbase_ff;
               dst_in    = dbase_ff;
               last_in   = prod_ff == (ADDR_BITS+1)'(ebh_ff);
               stat_in   = STAT_ELEM;
               active_in = prod_ff != (ADDR_BITS+1)'(ebh_ff);
               state_in  = FSM_IDLE;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = FSM_LD_A;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         active_ff <= 1'b0;
         rv_ff     <= 1'b0;
         k_ff      <= '0;
         zero_ff   <= 1'b0;
         src_ff    <= '0;
         dst_ff    <= '0;
         sbase_ff  <= '0;
         dbase_ff  <= '0;
         ebh_ff    <= EB_BITS'(4);
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         rv_ff     <= rv_in;
         k_ff      <= k_in;
         zero_ff   <= zero_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         sbase_ff  <= sbase_in;
         dbase_ff  <= dbase_in;
         ebh_ff    <= ebh_in;
      end
      last_ff   <= last_in;
      stat_ff   <= stat_in;
      r_ff      <= r_in;
      pv_ff     <= pv_in;
      ish_ff    <= ish_in;
      prod_ff   <= prod_in;
      stride_ff <= stride_in;
      osh_ff    <= osh_in;
      w_ff      <= w_in;
      back_ff   <= back_in;
      if (st_we) begin
         st_ff[k_ff] <= prod_ff[ADDR_BITS-1:0];
      end
   end

   // odometer row, last axis fastest
   assign carry[MAX_RANK] = 1'b1;

   for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
      tpag_axis_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clr       (clr),
         .load      (cld[g]),
         .step      (step),
         .carry_in  (carry[g+1]),
         .carry_out (carry[g]),
         .inc_out   (cinc[g]),
         .at_end    (cend[g])
      );
   end

   always_comb begin
      src_step = '0;
      for (int i = 0; i < MAX_RANK; i++) begin
         src_step = src_step | cinc[i];
      end
   end

endmodule

`default_nettype wire
